// ===== hw/rtl/rwc_pkg.sv =====
// Package for the RGB window convolution: widths, register indexes, pipeline control type.
package rwc_pkg;
   localparam int DEF_RADIUS    = 1;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int TAP_W         = 12;
   localparam int FRAC_W        = 11;
   localparam int PIX_W         = 24;
   localparam int COEF_W        = 60;
   localparam int TAPS_PER_WORD = 5;
   localparam int NUM_WORDS     = 5;
   localparam int CSR_IDX_W     = 3;
   localparam int XW            = 10;
   localparam int YW            = 12;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF0  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF4  = 3'd6;

   // Control that travels along the cell chain with a pixel column.
   typedef struct packed {
      logic          valid;
      logic          conv;
      logic          edge_pix;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [PIX_W-1:0] pix;
   } ctrl_type;
endpackage

// ===== hw/rtl/rgb_window_convolution.sv =====
// Top level of the RGB window convolution: line stores, cell chain, output queue.
//
// Usage: pixels enter in raster order on req_ (valid/ready), one per clock while req_ready is high.
// Registers are written on csr_ (index, data) while the block is idle:
// 0 image_width, 1 image_height, 2..6 coefficient words of five Q1.11 taps.
// Each request gives zero, one or two results on rsp_. When a pixel completes
// a window, the filtered pixel for (x-RADIUS, y-RADIUS) comes out, followed
// by the copied pixel if the incoming one lies on an edge; last_of_run marks
// the final result of the request.
// The path from request to first result runs through line store read,
// window shift and adder tree into the output queue. Throughput: one request
// per clock while the receiver keeps up; a request with two results needs
// two pops of the output port, so the eight-entry result queue fills and
// req_ready drops when the receiver stalls or double results pile up.
// Reset clears position, pipeline valids and queue, and restores registers
// to width 1024, height 1024, zero taps. Line stores are not cleared.
module rgb_window_convolution #(
   parameter int RADIUS    = rwc_pkg::DEF_RADIUS,
   parameter int MAX_WIDTH = rwc_pkg::DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_red,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_blue,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rwc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rwc_pkg::COEF_W-1:0]    csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rwc_pkg::XW-1:0]        rsp_out_x,
   output logic [rwc_pkg::YW-1:0]        rsp_out_y,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic                          rsp_last_of_run
);
   import rwc_pkg::*;

   localparam int SPAN   = 2 * RADIUS + 1;
   localparam int NLINES = 2 * RADIUS;
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int PW     = TAP_W + 8 + 4;
   localparam int AccW   = PW + 3;
   localparam int QDEPTH = 8;
   localparam int QAW    = 3;
   localparam int RW     = XW + YW + 25;

   // ---------------- registers ----------------
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [NUM_WORDS-1:0][COEF_W-1:0] coef_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 13'd1024;
         coef_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_data[10:0];
            REG_HEIGHT: height_ff <= csr_data[12:0];
            default: begin
               if (csr_index inside {[REG_COEF0:REG_COEF4]})
                  coef_ff[3'(csr_index - REG_COEF0)] <= csr_data;
            end
         endcase
      end
   end

   // clamped frame size
   logic [12:0] w_eff, h_eff;
   assign w_eff = (width_ff == '0) ? 13'd1 :
                  (width_ff > 11'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_ff);
   assign h_eff = (height_ff == '0) ? 13'd1 :
                  (height_ff > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_ff;

   // taps in raster order
   logic [SPAN-1:0][SPAN-1:0][TAP_W-1:0] tap_arr;
   always_comb begin
      for (int r = 0; r < SPAN; r++)
         for (int c = 0; c < SPAN; c++)
            tap_arr[r][c] = coef_ff[(r*SPAN+c) / TAPS_PER_WORD]
                                   [((r*SPAN+c) % TAPS_PER_WORD)*TAP_W +: TAP_W];
   end

   // ---------------- stage 0: position, edge decode, line store read ----------------
   logic [XW-1:0] col_ff;
   logic [YW-1:0] row_ff;
   logic          accept;
   logic [PIX_W-1:0] pix;
   logic [AW-1:0] idx;
   logic edge_c, conv_c;
   logic [13:0] x14, y14;

   assign accept = req_valid && req_ready;
   assign pix    = {req_red, req_green, req_blue};
   assign idx    = (14'(col_ff) < 14'(MAX_WIDTH)) ? AW'(col_ff) : AW'(MAX_WIDTH - 1);
   assign x14    = 14'(col_ff);
   assign y14    = 14'(row_ff);
   assign edge_c = x14 < 14'(RADIUS) || y14 < 14'(RADIUS) ||
                   x14 + 14'(RADIUS) >= 14'(w_eff) || y14 + 14'(RADIUS) >= 14'(h_eff);
   assign conv_c = x14 >= 14'(NLINES) && y14 >= 14'(NLINES) &&
                   x14 < 14'(w_eff) && y14 < 14'(h_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (x14 + 14'd1 >= 14'(w_eff)) begin
            col_ff <= '0;
            row_ff <= (y14 + 14'd1 >= 14'(h_eff)) ? '0 : YW'(row_ff + 1'b1);
         end else begin
            col_ff <= XW'(col_ff + 1'b1);
         end
      end
   end

   // Line store k holds the row NLINES-k lines above; each accept shifts the column up.
   logic [NLINES-1:0][PIX_W-1:0] line_rd;
   logic [AW-1:0] idx_ff;
   ctrl_type s1_ff, s1_in;

   assign s1_in = '{valid: accept, conv: conv_c, edge_pix: edge_c,
                    x: col_ff, y: row_ff, pix: pix};

   always_ff @(posedge clock) begin
      if (reset) s1_ff.valid <= 1'b0;
      else       s1_ff.valid <= s1_in.valid;
      s1_ff.conv     <= s1_in.conv;
      s1_ff.edge_pix <= s1_in.edge_pix;
      s1_ff.x        <= s1_in.x;
      s1_ff.y        <= s1_in.y;
      s1_ff.pix      <= s1_in.pix;
      idx_ff <= idx;
   end

   // Read a line at stage 0, write the shifted column at stage 1 (same address).
   // Back-to-back pixels always hit different addresses except at width one,
   // so forward the just-written column when addresses match.
   logic [NLINES-1:0][PIX_W-1:0] col_now;
   logic [NLINES-1:0][PIX_W-1:0] last_col_ff;
   logic [AW-1:0] last_idx_ff;
   logic          last_vld_ff;
   logic          fwd_ff;

   always_comb begin
      for (int k = 0; k < NLINES; k++)
         col_now[k] = fwd_ff ? last_col_ff[k] : line_rd[k];
   end

   logic [NLINES-1:0][PIX_W-1:0] col_wr;
   always_comb begin
      for (int k = 0; k + 1 < NLINES; k++) col_wr[k] = col_now[k+1];
      col_wr[NLINES-1] = s1_ff.pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_vld_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (s1_ff.valid) last_vld_ff <= 1'b1;
         fwd_ff <= accept && ((s1_ff.valid && idx == idx_ff) ||
                              (!s1_ff.valid && last_vld_ff && idx == last_idx_ff));
      end
      if (s1_ff.valid) begin
         last_col_ff <= col_wr;
         last_idx_ff <= idx_ff;
      end else if (fwd_ff) begin
         last_col_ff <= last_col_ff;
      end
   end

   for (genvar k = 0; k < NLINES; k++) begin : g_line
      rwc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
         .clock   (clock),
         .wr_en   (s1_ff.valid),
         .wr_addr (idx_ff),
         .wr_data (col_wr[k]),
         .rd_en   (accept),
         .rd_addr (idx),
         .rd_data (line_rd[k])
      );
   end

   // ---------------- stage 1: window cell chain ----------------
   logic [SPAN-1:0][PIX_W-1:0] new_col;
   always_comb begin
      for (int k = 0; k < NLINES; k++) new_col[k] = col_now[k];
      new_col[NLINES] = s1_ff.pix;
   end

   logic [SPAN:0][SPAN-1:0][PIX_W-1:0] chain;
   logic [SPAN-1:0][2:0][PW-1:0] psum;
   assign chain[SPAN] = new_col;

   // Cell c holds window column c; the rightmost cell takes the new column.
   for (genvar c = 0; c < SPAN; c++) begin : g_cell
      logic [SPAN-1:0][TAP_W-1:0] ctaps;
      always_comb begin
         for (int r = 0; r < SPAN; r++) ctaps[r] = tap_arr[r][c];
      end
      rwc_cell #(.SPAN(SPAN)) u_cell (
         .clock   (clock),
         .en      (s1_ff.valid),
         .col_in  (chain[c+1]),
         .col_out (chain[c]),
         .taps    (ctaps),
         .psum    (psum[c])
      );
   end

   ctrl_type s2_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_ff.valid <= 1'b0;
      else       s2_ff.valid <= s1_ff.valid;
      s2_ff.conv     <= s1_ff.conv;
      s2_ff.edge_pix <= s1_ff.edge_pix;
      s2_ff.x        <= s1_ff.x;
      s2_ff.y        <= s1_ff.y;
      s2_ff.pix      <= s1_ff.pix;
   end

   // ---------------- stage 2: sum columns, saturate, enqueue ----------------
   logic [2:0][7:0] filt;
   always_comb begin
      logic [AccW-1:0] acc;
      for (int ch = 0; ch < 3; ch++) begin
         acc = '0;
         for (int c = 0; c < SPAN; c++) acc = acc + AccW'(psum[c][ch]);
         acc = acc >> FRAC_W;
         filt[ch] = (acc > AccW'(255)) ? 8'hFF : acc[7:0];
      end
   end

   logic [RW-1:0] res_conv, res_edge;
   assign res_conv = {XW'(s2_ff.x - XW'(RADIUS)), YW'(s2_ff.y - YW'(RADIUS)),
                      filt[2], filt[1], filt[0], !s2_ff.edge_pix};
   assign res_edge = {s2_ff.x, s2_ff.y, s2_ff.pix, 1'b1};

   // result queue
   logic [QDEPTH-1:0][RW-1:0] q_ff;
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0]   cnt_ff;
   logic [1:0]     n_push;
   logic [1:0]     n_s1;
   logic           pop;

   assign n_push = s2_ff.valid ? (2'(s2_ff.conv) + 2'(s2_ff.edge_pix)) : 2'd0;
   assign n_s1   = s1_ff.valid ? (2'(s1_ff.conv) + 2'(s1_ff.edge_pix)) : 2'd0;
   assign pop    = rsp_valid && rsp_ready;
   // Hold requests unless the queue can absorb the results still in flight
   // plus two for a new request.
   assign req_ready = (5'(cnt_ff) + 5'(n_s1) + 5'(n_push) + 5'd2) <= 5'(QDEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (n_push != 2'd0) begin
            if (s2_ff.conv) begin
               q_ff[wp_ff] <= res_conv;
               if (s2_ff.edge_pix) q_ff[QAW'(wp_ff + 1'b1)] <= res_edge;
            end else begin
               q_ff[wp_ff] <= res_edge;
            end
         end
         wp_ff  <= QAW'(wp_ff + n_push);
         rp_ff  <= QAW'(rp_ff + QAW'(pop));
         cnt_ff <= cnt_ff + 4'(n_push) - 4'(pop);
      end
   end

   assign rsp_valid = cnt_ff != '0;
   assign {rsp_out_x, rsp_out_y, rsp_out_red, rsp_out_green, rsp_out_blue,
           rsp_last_of_run} = q_ff[rp_ff];

   // ---------------- checks ----------------
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(QDEPTH)) else $error("result queue overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_pipe_follow: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 s2_ff.valid) else $error("request lost in pipeline");
endmodule

// ===== hw/rtl/rwc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rwc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hw/rtl/rwc_cell.sv =====
// One window column cell: holds one column of pixels and its tap products.
module rwc_cell #(
   parameter int SPAN = 3
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [SPAN-1:0][rwc_pkg::PIX_W-1:0] col_in,
   output logic [SPAN-1:0][rwc_pkg::PIX_W-1:0] col_out,
   input  logic [SPAN-1:0][rwc_pkg::TAP_W-1:0] taps,
   output logic [2:0][rwc_pkg::TAP_W+8+4-1:0]  psum
);
   import rwc_pkg::*;
   localparam int PW = TAP_W + 8 + 4;

   logic [SPAN-1:0][PIX_W-1:0] col_ff;
   logic [2:0][PW-1:0] sum_in;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int r = 0; r < SPAN; r++)
            sum_in[ch] = sum_in[ch] + PW'(taps[r] * col_ff[r][ch*8 +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) col_ff <= col_in;
   end

   assign col_out = col_ff;
   assign psum    = sum_in;
endmodule
